[rtl/core/shape_area_volume_unit_assert.svh]
// ----------------------------------------------------------------------------
// shape_area_volume_unit assertion macros
// clocked assertion wrappers; define ASSERT_OFF to compile them away
// ----------------------------------------------------------------------------
`ifndef SHAPE_AREA_VOLUME_UNIT_ASSERT_SVH
`define SHAPE_AREA_VOLUME_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define SAV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SAV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SAV_ASSERT(lbl, clk, rst_n, prop, msg)
`define SAV_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/sav_pkg.sv]
// ----------------------------------------------------------------------------
// sav_pkg
// shared codes, constants and types of the shape area / volume pipeline
// ----------------------------------------------------------------------------
package sav_pkg;

    localparam logic [3:0] FN_CIRCLE        = 4'd0;
    localparam logic [3:0] FN_SQUARE        = 4'd1;
    localparam logic [3:0] FN_BOX           = 4'd2;
    localparam logic [3:0] FN_PARALLELOGRAM = 4'd3;
    localparam logic [3:0] FN_TRIANGLE      = 4'd4;
    localparam logic [3:0] FN_ELLIPSE       = 4'd5;
    localparam logic [3:0] FN_SPHERE        = 4'd6;
    localparam logic [3:0] FN_CUBE          = 4'd7;
    localparam logic [3:0] FN_CONE          = 4'd8;
    localparam logic [3:0] FN_CYLINDER      = 4'd9;
    localparam logic [3:0] FN_PYRAMID       = 4'd10;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_TRI_BAD = 2'd2;
    localparam logic [1:0] ST_SAT     = 2'd3;

    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [31:0] DIV3_RECIP  = 32'hAAAAAAAB;

    // cordic datapath width, signed
    localparam int CW = 34;
    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30  = 34'sd1073741824;

    localparam int SQRT_STEPS = 51;
    localparam int HERON_LAT  = 4 + SQRT_STEPS;
    localparam int FINAL_LAT  = 4;

    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
        30'h0000001F, 30'h0000000F, 30'h00000007, 30'h00000003, 30'h00000001,
        30'h00000000, 30'h00000000
    };

    typedef struct packed {
        logic [3:0]  func;
        logic [31:0] a;
        logic [31:0] h;
        logic [32:0] a43;
        logic [31:0] h3;
        logic [47:0] aa48;
        logic [47:0] ab48;
        logic        tri_bad;
    } sav_side_t;

    typedef struct packed {
        sav_side_t   side;
        logic [50:0] heron;
        logic [30:0] sine;
    } sav_fin_t;

endpackage

[rtl/core/shape_area_volume_unit.sv]
// ----------------------------------------------------------------------------
// shape_area_volume_unit
// area or volume of one plane shape or solid per beat, Q16.16 in, Q48.16 out
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  command   start / busy         func, dim_a, dim_b, dim_c, height, angle
//  result    done (strobe)        measure, status
//
//  a new beat can enter every cycle; busy is tied low
//  every shape takes the same path through the input stage, the heron pipeline and
//  sav_final, whose longest part is the 51-stage square root of the heron product
//  the cordic runs beside the root and its sine waits in a delay line
//  reset clears the valid bits only; results are a one-cycle strobe
// ----------------------------------------------------------------------------
`include "shape_area_volume_unit_assert.svh"

module shape_area_volume_unit
    import sav_pkg::*;
#(
    parameter int CORDIC_STEPS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  func,
    input  logic [31:0] dim_a,
    input  logic [31:0] dim_b,
    input  logic [31:0] dim_c,
    input  logic [31:0] height,
    input  logic [31:0] angle,
    output logic        done,
    output logic [63:0] measure,
    output logic [1:0]  status
);

    localparam int SINE_DLY  = HERON_LAT - CORDIC_STEPS;
    localparam int TOTAL_LAT = 1 + HERON_LAT + FINAL_LAT;

    logic        accept;
    logic [63:0] aa_full, ab_full, a_q3_full, h_q3_full;
    logic [32:0] sum_bc, sum_ac, sum_ab;
    logic [33:0] sum_abc;
    logic        tri_bad;
    logic [31:0] ang_clamp, ang_fold;
    sav_side_t   side_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign aa_full   = dim_a * dim_a;
    assign ab_full   = dim_a * dim_b;
    // x/3 as reciprocal product, exact for 32-bit x
    assign a_q3_full = dim_a * DIV3_RECIP;
    assign h_q3_full = height * DIV3_RECIP;

    assign sum_bc  = {1'b0, dim_b} + {1'b0, dim_c};
    assign sum_ac  = {1'b0, dim_a} + {1'b0, dim_c};
    assign sum_ab  = {1'b0, dim_a} + {1'b0, dim_b};
    assign sum_abc = {2'b0, dim_a} + {2'b0, dim_b} + {2'b0, dim_c};
    assign tri_bad = (sum_bc < {1'b0, dim_a}) || (sum_ac < {1'b0, dim_b})
                  || (sum_ab < {1'b0, dim_c});

    assign ang_clamp = (angle > PI_Q30) ? PI_Q30 : angle;
    assign ang_fold  = (ang_clamp > HALF_PI_Q30) ? (PI_Q30 - ang_clamp) : ang_clamp;

    always_comb
    begin
        side_next.func    = func;
        side_next.a       = dim_a;
        side_next.h       = height;
        side_next.a43     = {1'b0, dim_a} + {2'b0, a_q3_full[63:33]};
        side_next.h3      = {1'b0, h_q3_full[63:33]};
        side_next.aa48    = aa_full[63:16];
        side_next.ab48    = ab_full[63:16];
        side_next.tri_bad = tri_bad;
    end

    // input stage
    logic        v_in_reg;
    sav_side_t   side_in_reg;
    logic [33:0] s1_reg, s2_reg, s3_reg, s4_reg;
    logic [30:0] ang_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_in_reg <= 1'b0;
        else
            v_in_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        side_in_reg <= side_next;
        ang_reg     <= ang_fold[30:0];
        s1_reg      <= tri_bad ? '0 : sum_abc;
        s2_reg      <= tri_bad ? '0 : ({1'b0, sum_bc} - {2'b0, dim_a});
        s3_reg      <= tri_bad ? '0 : ({1'b0, sum_ac} - {2'b0, dim_b});
        s4_reg      <= tri_bad ? '0 : ({1'b0, sum_ab} - {2'b0, dim_c});
    end

    // heron root and sine in parallel
    logic        h_valid;
    sav_side_t   h_side;
    logic [50:0] h_root;
    logic [30:0] sine_raw;

    sav_heron u_heron
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_in_reg),
        .in_side   (side_in_reg),
        .s1        (s1_reg),
        .s2        (s2_reg),
        .s3        (s3_reg),
        .s4        (s4_reg),
        .out_valid (h_valid),
        .out_side  (h_side),
        .out_root  (h_root)
    );

    sav_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic
    (
        .clk   (clk),
        .angle (ang_reg),
        .sine  (sine_raw)
    );

    logic [30:0] sine_dly_reg [SINE_DLY];

    always_ff @(posedge clk)
    begin
        sine_dly_reg[0] <= sine_raw;
        for (int k = 1; k < SINE_DLY; k++)
            sine_dly_reg[k] <= sine_dly_reg[k-1];
    end

    sav_fin_t fin;

    always_comb
    begin
        fin.side  = h_side;
        fin.heron = h_root;
        fin.sine  = sine_dly_reg[SINE_DLY-1];
    end

    sav_final u_final
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (h_valid),
        .in_fin   (fin),
        .done     (done),
        .measure  (measure),
        .status   (status)
    );

    `SAV_ASSERT(a_latency, clk, rst_n, accept |-> ##(TOTAL_LAT) done, "missing result strobe")
    `SAV_ASSERT(a_no_ghost, clk, rst_n, done |-> $past(accept, TOTAL_LAT), "result without command")
    `SAV_ASSERT(a_never_busy, clk, rst_n, !busy, "busy raised")

endmodule

[rtl/core/sav_cordic.sv]
// ----------------------------------------------------------------------------
// sav_cordic
// pipelined rotation-mode cordic, one rotation per stage, clamped sine out
// ----------------------------------------------------------------------------
module sav_cordic
    import sav_pkg::*;
#(
    parameter int STEPS = 24
)
(
    input  logic        clk,
    input  logic [30:0] angle,
    output logic [30:0] sine
);

    logic signed [CW-1:0] x_reg [STEPS];
    logic signed [CW-1:0] y_reg [STEPS];
    logic signed [CW-1:0] z_reg [STEPS];

    genvar i;
    generate
        for (i = 0; i < STEPS; i++)
        begin : g_step
            logic signed [CW-1:0] x_in, y_in, z_in, dx, dy, at;
            if (i == 0)
            begin : g_first
                assign x_in = GAIN_Q30;
                assign y_in = '0;
                assign z_in = signed'({{(CW-31){1'b0}}, angle});
            end
            else
            begin : g_rest
                assign x_in = x_reg[i-1];
                assign y_in = y_reg[i-1];
                assign z_in = z_reg[i-1];
            end
            assign dx = y_in >>> i;
            assign dy = x_in >>> i;
            assign at = signed'({{(CW-30){1'b0}}, ATAN_Q30[i]});
            always_ff @(posedge clk)
            begin
                if (!z_in[CW-1])
                begin
                    x_reg[i] <= x_in - dx;
                    y_reg[i] <= y_in + dy;
                    z_reg[i] <= z_in - at;
                end
                else
                begin
                    x_reg[i] <= x_in + dx;
                    y_reg[i] <= y_in - dy;
                    z_reg[i] <= z_in + at;
                end
            end
        end
    endgenerate

    logic signed [CW-1:0] y_last;
    assign y_last = y_reg[STEPS-1];

    always_comb
    begin
        if (y_last[CW-1])
            sine = '0;
        else if (y_last > ONE_Q30)
            sine = ONE_Q30[30:0];
        else
            sine = y_last[30:0];
    end

endmodule

[rtl/core/sav_heron.sv]
// ----------------------------------------------------------------------------
// sav_heron
// heron product of the four side terms and a one-bit-per-stage square root
// ----------------------------------------------------------------------------
module sav_heron
    import sav_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  sav_side_t   in_side,
    input  logic [33:0] s1,
    input  logic [33:0] s2,
    input  logic [33:0] s3,
    input  logic [33:0] s4,
    output logic        out_valid,
    output sav_side_t   out_side,
    output logic [50:0] out_root
);

    localparam int QW = 2 * SQRT_STEPS;
    localparam int RW = SQRT_STEPS + 3;

    // product stages
    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    sav_side_t   side1_reg, side2_reg, side3_reg, side4_reg;
    logic [67:0] p12_reg, p34_reg;
    logic [67:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic [67:0] ll3_reg, hh3_reg;
    logic [68:0] cross_reg;
    logic [QW-1:0] q4_reg;
    logic [135:0] prod_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign prod_full = {68'b0, ll3_reg} + {33'b0, cross_reg, 34'b0} + {hh3_reg, 68'b0};

    always_ff @(posedge clk)
    begin
        side1_reg <= in_side;
        p12_reg   <= s1 * s2;
        p34_reg   <= s3 * s4;
        side2_reg <= side1_reg;
        ll_reg    <= p12_reg[33:0] * p34_reg[33:0];
        lh_reg    <= p12_reg[33:0] * p34_reg[67:34];
        hl_reg    <= p12_reg[67:34] * p34_reg[33:0];
        hh_reg    <= p12_reg[67:34] * p34_reg[67:34];
        side3_reg <= side2_reg;
        ll3_reg   <= ll_reg;
        hh3_reg   <= hh_reg;
        cross_reg <= {1'b0, lh_reg} + {1'b0, hl_reg};
        side4_reg <= side3_reg;
        q4_reg    <= {2'b0, prod_full[135:36]};
    end

    // root stages, two radicand bits per stage
    logic          v_reg    [SQRT_STEPS];
    sav_side_t     side_reg [SQRT_STEPS];
    logic [QW-1:0] q_reg    [SQRT_STEPS];
    logic [RW-1:0] rem_reg  [SQRT_STEPS];
    logic [50:0]   root_reg [SQRT_STEPS];

    genvar j;
    generate
        for (j = 0; j < SQRT_STEPS; j++)
        begin : g_root
            logic          v_in;
            sav_side_t     side_in;
            logic [QW-1:0] q_in;
            logic [RW-1:0] rem_in, cur, trial;
            logic [50:0]   root_in;
            if (j == 0)
            begin : g_first
                assign v_in    = v4_reg;
                assign side_in = side4_reg;
                assign q_in    = q4_reg;
                assign rem_in  = '0;
                assign root_in = '0;
            end
            else
            begin : g_rest
                assign v_in    = v_reg[j-1];
                assign side_in = side_reg[j-1];
                assign q_in    = q_reg[j-1];
                assign rem_in  = rem_reg[j-1];
                assign root_in = root_reg[j-1];
            end
            assign cur   = {rem_in[RW-3:0], q_in[QW-1:QW-2]};
            assign trial = {1'b0, root_in, 2'b01};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[j] <= 1'b0;
                else
                    v_reg[j] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                side_reg[j] <= side_in;
                q_reg[j]    <= {q_in[QW-3:0], 2'b00};
                if (cur >= trial)
                begin
                    rem_reg[j]  <= cur - trial;
                    root_reg[j] <= {root_in[49:0], 1'b1};
                end
                else
                begin
                    rem_reg[j]  <= cur;
                    root_reg[j] <= {root_in[49:0], 1'b0};
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[SQRT_STEPS-1];
    assign out_side  = side_reg[SQRT_STEPS-1];
    assign out_root  = root_reg[SQRT_STEPS-1];

endmodule

[rtl/core/sav_final.sv]
// ----------------------------------------------------------------------------
// sav_final
// pi scaling, second product, saturation and result selection
// ----------------------------------------------------------------------------
`include "shape_area_volume_unit_assert.svh"

module sav_final
    import sav_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  sav_fin_t    in_fin,
    output logic        done,
    output logic [63:0] measure,
    output logic [1:0]  status
);

    logic        v1_reg, v2_reg, v3_reg, done_reg;
    sav_fin_t    fin1_reg, fin2_reg, fin3_reg;
    logic [63:0] plo1_reg;
    logic [47:0] phi1_reg;
    logic [49:0] pim2_reg, pim3_reg;
    logic [65:0] plo3_reg;
    logic [52:0] phi3_reg;
    logic [63:0] measure_reg;
    logic [1:0]  status_reg;

    logic [47:0] base;
    logic [79:0] pi_sum;
    logic [50:0] x_op;
    logic [33:0] y_op;
    logic [84:0] prod;
    logic        sat;
    logic [63:0] measure_next;
    logic [1:0]  status_next;

    assign base   = (in_fin.side.func == FN_ELLIPSE) ? in_fin.side.ab48 : in_fin.side.aa48;
    assign pi_sum = {16'b0, plo1_reg} + {phi1_reg, 32'b0};

    always_comb
    begin
        unique case (fin2_reg.side.func)
            FN_SPHERE:
            begin
                x_op = {1'b0, pim2_reg};
                y_op = {1'b0, fin2_reg.side.a43};
            end
            FN_CONE:
            begin
                x_op = {1'b0, pim2_reg};
                y_op = {2'b0, fin2_reg.side.h3};
            end
            FN_CYLINDER:
            begin
                x_op = {1'b0, pim2_reg};
                y_op = {2'b0, fin2_reg.side.h};
            end
            FN_CUBE:
            begin
                x_op = {3'b0, fin2_reg.side.aa48};
                y_op = {2'b0, fin2_reg.side.a};
            end
            FN_PARALLELOGRAM:
            begin
                x_op = {3'b0, fin2_reg.side.ab48};
                y_op = {3'b0, fin2_reg.sine};
            end
            FN_PYRAMID:
            begin
                x_op = fin2_reg.heron;
                y_op = {2'b0, fin2_reg.side.h3};
            end
            default:
            begin
                x_op = '0;
                y_op = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fin1_reg    <= in_fin;
        plo1_reg    <= base[31:0] * PI_Q30;
        phi1_reg    <= base[47:32] * PI_Q30;
        fin2_reg    <= fin1_reg;
        pim2_reg    <= pi_sum[79:30];
        fin3_reg    <= fin2_reg;
        pim3_reg    <= pim2_reg;
        plo3_reg    <= x_op[31:0] * y_op;
        phi3_reg    <= x_op[50:32] * y_op;
        measure_reg <= measure_next;
        status_reg  <= status_next;
    end

    // only the Q16 products can pass 64 bits
    assign prod = {19'b0, plo3_reg} + {phi3_reg, 32'b0};
    assign sat  = |prod[84:80];

    always_comb
    begin
        measure_next = '0;
        status_next  = ST_OK;
        unique case (fin3_reg.side.func)
            FN_CIRCLE, FN_ELLIPSE:
                measure_next = {14'b0, pim3_reg};
            FN_SQUARE:
                measure_next = {16'b0, fin3_reg.side.aa48};
            FN_BOX:
                measure_next = {16'b0, fin3_reg.side.ab48};
            FN_PARALLELOGRAM:
                measure_next = {9'b0, prod[84:30]};
            FN_TRIANGLE:
            begin
                if (fin3_reg.side.tri_bad)
                    status_next = ST_TRI_BAD;
                else
                    measure_next = {13'b0, fin3_reg.heron};
            end
            FN_SPHERE, FN_CUBE, FN_CONE, FN_CYLINDER, FN_PYRAMID:
            begin
                priority if (fin3_reg.side.func == FN_PYRAMID && fin3_reg.side.tri_bad)
                    status_next = ST_TRI_BAD;
                else if (sat)
                begin
                    measure_next = '1;
                    status_next  = ST_SAT;
                end
                else
                    measure_next = prod[79:16];
            end
            default:
                status_next = ST_UNKNOWN;
        endcase
    end

    assign done    = done_reg;
    assign measure = measure_reg;
    assign status  = status_reg;

    `SAV_ASSERT(a_tri_bad_zero, clk, rst_n, done && status == ST_TRI_BAD |-> measure == '0, "bad triangle with nonzero measure")
    `SAV_ASSERT(a_sat_all_ones, clk, rst_n, done && status == ST_SAT |-> &measure, "saturated result not all ones")
    `SAV_ASSERT(a_unknown_zero, clk, rst_n, done && status == ST_UNKNOWN |-> measure == '0, "unknown shape with nonzero measure")
    `SAV_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !done_reg, "strobe right after reset")

endmodule
